FILE: design/bcls_pkg.sv
// Shared constants and types for the button short/long press classifier.
// Used by bcls_lane, bcls_merge and button_short_long_press_classifier.
`timescale 1ns / 1ps
`default_nettype none
package bcls_pkg;

    localparam int BUTTONS_DEF    = 4;
    localparam int COUNT_BITS_DEF = 16;

    localparam int NUM_MASKS  = 4;
    localparam int MASK_W     = 8;
    localparam int LPT_W      = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [LPT_W-1:0] LPT_RESET = 16'd1000;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic PRESS_SHORT = 1'b0;
    localparam logic PRESS_LONG  = 1'b1;

    typedef enum logic [2:0] {
        REG_MASK_0     = 3'd0,
        REG_MASK_1     = 3'd1,
        REG_MASK_2     = 3'd2,
        REG_MASK_3     = 3'd3,
        REG_LONG_TICKS = 3'd4
    } bcls_reg_t;

    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } bcls_lane_evt_t;

endpackage
`default_nettype wire

FILE: design/bcls_lane.sv
// One button lane: pressed flag, saturating held-tick counter, event detect.
// Depends on bcls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bcls_lane #(
    parameter int COUNT_BITS = bcls_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_accept,
    input  wire logic                          item_kind,
    input  wire logic [bcls_pkg::MASK_W-1:0]   item_port,
    input  wire logic [bcls_pkg::MASK_W-1:0]   line_mask,
    input  wire logic [bcls_pkg::LPT_W-1:0]    long_ticks,
    output bcls_pkg::bcls_lane_evt_t           lane_evt
);
    import bcls_pkg::*;

    localparam int CMP_W = (COUNT_BITS > LPT_W) ? COUNT_BITS : LPT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  pressed_reg, pressed_next;
    logic [COUNT_BITS-1:0] held_reg, held_next;
    logic                  now_pressed;
    logic                  flag_mid;
    logic                  short_evt;
    logic                  long_evt;

    assign now_pressed = |(~item_port & line_mask);

    always_comb begin
        flag_mid  = pressed_reg;
        held_next = held_reg;
        short_evt = 1'b0;
        if (item_kind == KIND_TICK) begin
            if (held_reg != COUNT_MAX) begin
                held_next = held_reg + COUNT_BITS'(1);
            end
        end else if (now_pressed != pressed_reg) begin
            flag_mid = now_pressed;
            if (now_pressed) begin
                held_next = '0;
            end else begin
                short_evt = 1'b1;
            end
        end
        long_evt     = flag_mid && (CMP_W'(held_next) > CMP_W'(long_ticks));
        pressed_next = flag_mid & ~long_evt;
    end

    assign lane_evt.short_evt = short_evt;
    assign lane_evt.long_evt  = long_evt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            held_reg    <= '0;
        end else if (item_accept) begin
            pressed_reg <= pressed_next;
            held_reg    <= held_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/bcls_merge.sv
// Merge stage: gathers lane events into an ordered pending set and a hold slot,
// then issues one event per cycle while evt_ready is high. Depends on bcls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bcls_merge #(
    parameter int BUTTONS = bcls_pkg::BUTTONS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     item_accept,
    input  wire bcls_pkg::bcls_lane_evt_t lane_evt [BUTTONS],
    output logic                          item_ready,
    output logic                          evt_valid,
    input  wire logic                     evt_ready,
    output logic [1:0]                    evt_button,
    output logic                          evt_kind,
    output logic                          evt_last
);
    import bcls_pkg::*;

    localparam int EVW = 2 * BUTTONS;

    logic [EVW-1:0] cur_reg, cur_next;
    logic [EVW-1:0] hold_reg, hold_next;
    logic [EVW-1:0] new_vec;
    logic [EVW-1:0] cur_rest;
    logic [EVW-1:0] lowest;
    logic           out_fire;
    logic           cur_done;

    // shorts in the low half, longs in the high half: lowest bit first
    always_comb begin
        for (int b = 0; b < BUTTONS; b++) begin
            new_vec[b]         = lane_evt[b].short_evt;
            new_vec[BUTTONS+b] = lane_evt[b].long_evt;
        end
    end

    assign cur_rest = cur_reg & (cur_reg - EVW'(1));
    assign lowest   = cur_reg & ~cur_rest;

    always_comb begin
        evt_button = 2'd0;
        evt_kind   = PRESS_SHORT;
        for (int b = 0; b < BUTTONS; b++) begin
            if (lowest[b]) begin
                evt_button = 2'(b);
                evt_kind   = PRESS_SHORT;
            end
            if (lowest[BUTTONS+b]) begin
                evt_button = 2'(b);
                evt_kind   = PRESS_LONG;
            end
        end
    end

    assign evt_valid  = |cur_reg;
    assign evt_last   = ~|cur_rest;
    assign item_ready = ~|hold_reg;
    assign out_fire   = evt_valid & evt_ready;
    assign cur_done   = ~evt_valid | (out_fire & evt_last);

    always_comb begin
        cur_next  = cur_reg;
        hold_next = hold_reg;
        if (cur_done) begin
            if (|hold_reg) begin
                cur_next  = hold_reg;
                hold_next = '0;
            end else begin
                cur_next = item_accept ? new_vec : '0;
            end
        end else begin
            if (out_fire) begin
                cur_next = cur_rest;
            end
            if (item_accept) begin
                hold_next = new_vec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            hold_reg <= '0;
        end else begin
            cur_reg  <= cur_next;
            hold_reg <= hold_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/button_short_long_press_classifier.sv
// Top level of the button short/long press classifier: APB registers,
// one bcls_lane per button and the bcls_merge output stage. Depends on bcls_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one item per clock cycle while s_ready is high; every button lane
// updates in that same cycle. The press events of an item are issued one
// after another on the result channel as m_ready allows, and an item with
// no event yields no output. A hold slot behind the output stage takes the
// next item while the current events drain; s_ready falls only when that slot
// is full. Registers: line masks of buttons 0..3 at 0x00..0x0C, long-press
// threshold at 0x10. Buttons beyond four use the fixed mask 1 << (i mod 8).
module button_short_long_press_classifier #(
    parameter int BUTTONS    = bcls_pkg::BUTTONS_DEF,
    parameter int COUNT_BITS = bcls_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bcls_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bcls_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bcls_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic [7:0]                        s_port_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [1:0]                        m_button_index,
    output logic                                   m_press_kind,
    output logic                                   m_last_event
);
    import bcls_pkg::*;

    logic [MASK_W-1:0] mask_reg [NUM_MASKS];
    logic [LPT_W-1:0]  long_ticks_reg;
    bcls_reg_t         reg_idx;
    logic              cfg_write;
    logic              item_accept;
    bcls_lane_evt_t    lane_evt [BUTTONS];

    assign pready    = 1'b1;
    assign reg_idx   = bcls_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_MASKS; i++) begin
                mask_reg[i] <= MASK_W'(1 << i);
            end
            long_ticks_reg <= LPT_RESET;
        end else if (cfg_write) begin
            case (reg_idx) inside
                REG_MASK_0, REG_MASK_1, REG_MASK_2, REG_MASK_3: begin
                    mask_reg[reg_idx[1:0]] <= pwdata[MASK_W-1:0];
                end
                REG_LONG_TICKS: begin
                    long_ticks_reg <= pwdata[LPT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx) inside
            REG_MASK_0, REG_MASK_1, REG_MASK_2, REG_MASK_3: begin
                prdata = APB_DATA_W'(mask_reg[reg_idx[1:0]]);
            end
            REG_LONG_TICKS: begin
                prdata = APB_DATA_W'(long_ticks_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign item_accept = s_valid & s_ready;

    for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
        localparam logic [MASK_W-1:0] FIXED_MASK = MASK_W'(1 << (i % 8));
        logic [MASK_W-1:0] lane_mask;

        if (i < NUM_MASKS) begin : g_cfg_mask
            assign lane_mask = mask_reg[i];
        end else begin : g_fixed_mask
            assign lane_mask = FIXED_MASK;
        end

        bcls_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .item_accept (item_accept),
            .item_kind   (s_kind),
            .item_port   (s_port_value),
            .line_mask   (lane_mask),
            .long_ticks  (long_ticks_reg),
            .lane_evt    (lane_evt[i])
        );
    end

    bcls_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .lane_evt    (lane_evt),
        .item_ready  (s_ready),
        .evt_valid   (m_valid),
        .evt_ready   (m_ready),
        .evt_button  (m_button_index),
        .evt_kind    (m_press_kind),
        .evt_last    (m_last_event)
    );

`ifndef SYNTHESIS
    a_hold_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("hold slot full while output stage empty");

    a_more_after_nonlast: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_event) |=> m_valid)
        else $error("item events cut short");

    a_long_after_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_event && m_press_kind == PRESS_LONG)
        |=> (m_press_kind == PRESS_LONG))
        else $error("short press after long press within one item");
`endif

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for button_short_long_press_classifier: a directed stimulus table, then
// randomized press, release and tick traffic; typed rows are checked against their listed
// events, all else against an in-bench predictor. Depends on bcls_pkg and the classifier RTL.
`timescale 1ns / 1ps
module tb;
    import bcls_pkg::*;

    localparam int NBTN           = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_ITEMS    = 50;
    localparam int RX_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0] button_index;
        logic       press_kind;
        logic       last_event;
    } press_evt_t;

    localparam press_evt_t NO_EVT = '0;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_op_t;

    typedef struct packed {
        row_op_t                 op;
        logic                    kind;
        logic [7:0]              sample_byte;
        bcls_reg_t               cfg_reg;
        logic [LPT_W-1:0]        cfg_value;
        logic                    typed;
        logic [2:0]              n_typed;
        press_evt_t [NBTN-1:0]   evts;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_kind = KIND_TICK;
    logic [7:0]              s_port_value = 8'hFF;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_button_index;
    logic                    m_press_kind;
    logic                    m_last_event;

    // side data that travels with the item on the input channel
    logic                    row_typed = 1'b0;
    logic [2:0]              row_n = '0;
    press_evt_t [NBTN-1:0]   row_evts = '0;

    logic [MASK_W-1:0]       line_mask [NBTN];
    logic [LPT_W-1:0]        long_ticks;
    logic                    btn_pressed [NBTN];
    logic [15:0]             btn_held [NBTN];

    press_evt_t              press_events_q [$];
    stim_row_t               stim_tbl [$];

    press_evt_t [NBTN-1:0]   mon_evts;
    press_evt_t              evt_want;
    int                      mon_n;
    int                      mon_i;
    int                      err_count = 0;
    int                      cycle_count = 0;
    logic                    tx_idle = 1'b1;
    logic                    rx_idle = 1'b1;
    logic                    rx_hold_req = 1'b0;

    button_short_long_press_classifier u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_port_value   (s_port_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_index (m_button_index),
        .m_press_kind   (m_press_kind),
        .m_last_event   (m_last_event)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int classify_item(input logic kind, input logic [7:0] sample_byte,
                                         output press_evt_t [NBTN-1:0] evts);
        int n;
        int i;
        logic now_pressed;
        n = 0;
        evts = '0;
        if (kind == KIND_TICK) begin
            for (i = 0; i < NBTN; i++) begin
                if (btn_held[i] != 16'hFFFF)
                    btn_held[i] = btn_held[i] + 16'd1;
            end
        end else begin
            for (i = 0; i < NBTN; i++) begin
                now_pressed = |(~sample_byte & line_mask[i]);
                if (now_pressed != btn_pressed[i]) begin
                    btn_pressed[i] = now_pressed;
                    if (now_pressed) begin
                        btn_held[i] = '0;
                    end else begin
                        evts[n].button_index = i[1:0];
                        evts[n].press_kind = PRESS_SHORT;
                        n++;
                    end
                end
            end
        end
        for (i = 0; i < NBTN; i++) begin
            if (btn_pressed[i] && btn_held[i] > long_ticks) begin
                btn_pressed[i] = 1'b0;
                evts[n].button_index = i[1:0];
                evts[n].press_kind = PRESS_LONG;
                n++;
            end
        end
        if (n > 0)
            evts[n-1].last_event = 1'b1;
        return n;
    endfunction

    function automatic press_evt_t ev(input logic [1:0] idx, input logic kind,
                                      input logic last);
        press_evt_t e;
        e.button_index = idx;
        e.press_kind = kind;
        e.last_event = last;
        return e;
    endfunction

    function automatic stim_row_t typed_row(input logic kind, input logic [7:0] sample_byte,
                                            input logic [2:0] n,
                                            input press_evt_t [NBTN-1:0] evts);
        stim_row_t r;
        r = '0;
        r.op = ROW_ITEM;
        r.kind = kind;
        r.sample_byte = sample_byte;
        r.typed = 1'b1;
        r.n_typed = n;
        r.evts = evts;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic kind, input logic [7:0] sample_byte);
        stim_row_t r;
        r = '0;
        r.op = ROW_ITEM;
        r.kind = kind;
        r.sample_byte = sample_byte;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input bcls_reg_t sel, input logic [LPT_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.op = ROW_CFG;
        r.cfg_reg = sel;
        r.cfg_value = value;
        return r;
    endfunction

    task automatic apb_write(input bcls_reg_t sel, input logic [LPT_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({sel, 2'b00});
        pwdata <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (sel)
            REG_MASK_0, REG_MASK_1, REG_MASK_2, REG_MASK_3: begin
                line_mask[int'(sel)] = value[MASK_W-1:0];
            end
            REG_LONG_TICKS: begin
                long_ticks = value;
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic send_item(input logic kind, input logic [7:0] sample_byte,
                             input logic typed, input logic [2:0] n_typed,
                             input press_evt_t [NBTN-1:0] evts);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_port_value <= sample_byte;
        row_typed <= typed;
        row_n <= n_typed;
        row_evts <= evts;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (press_events_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            mon_n = classify_item(s_kind, s_port_value, mon_evts);
            if (row_typed) begin
                mon_n = row_n;
                mon_evts = row_evts;
            end
            for (mon_i = 0; mon_i < mon_n; mon_i++)
                press_events_q.push_back(mon_evts[mon_i]);
        end
        if (aresetn && m_valid && m_ready) begin
            if (press_events_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual button %0d kind %0d last %0d",
                         $time, m_button_index, m_press_kind, m_last_event);
                err_count++;
            end else begin
                evt_want = press_events_q.pop_front();
                if (m_button_index !== evt_want.button_index) begin
                    $display("%0t: button_index mismatch, expected %0d, actual %0d",
                             $time, evt_want.button_index, m_button_index);
                    err_count++;
                end
                if (m_press_kind !== evt_want.press_kind) begin
                    $display("%0t: press_kind mismatch, expected %0d, actual %0d",
                             $time, evt_want.press_kind, m_press_kind);
                    err_count++;
                end
                if (m_last_event !== evt_want.last_event) begin
                    $display("%0t: last_event mismatch, expected %0d, actual %0d",
                             $time, evt_want.last_event, m_last_event);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 15) : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int p;
        int b;
        int k;
        logic kind;
        logic [7:0] sample_byte;
        logic [7:0] last_byte;
        logic [7:0] mask;
        logic [LPT_W-1:0] lpt;

        for (b = 0; b < NBTN; b++) begin
            line_mask[b] = 8'h01 << b;
            btn_pressed[b] = 1'b0;
            btn_held[b] = '0;
        end
        long_ticks = LPT_RESET;

        stim_tbl.push_back(typed_row(KIND_TICK, 8'h00, 3'd0, '0));
        stim_tbl.push_back(typed_row(KIND_SAMPLE, 8'hFF, 3'd0, '0));
        stim_tbl.push_back(typed_row(KIND_SAMPLE, 8'hFE, 3'd0, '0));
        stim_tbl.push_back(typed_row(KIND_SAMPLE, 8'hFF, 3'd1,
                           {NO_EVT, NO_EVT, NO_EVT, ev(2'd0, PRESS_SHORT, 1'b1)}));
        stim_tbl.push_back(typed_row(KIND_SAMPLE, 8'hF0, 3'd0, '0));
        stim_tbl.push_back(typed_row(KIND_SAMPLE, 8'hFF, 3'd4,
                           {ev(2'd3, PRESS_SHORT, 1'b1), ev(2'd2, PRESS_SHORT, 1'b0),
                            ev(2'd1, PRESS_SHORT, 1'b0), ev(2'd0, PRESS_SHORT, 1'b0)}));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'h00));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'hF5));
        stim_tbl.push_back(item_row(KIND_TICK, 8'hAA));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'hFF));
        stim_tbl.push_back(cfg_row(REG_LONG_TICKS, 16'd0));
        stim_tbl.push_back(typed_row(KIND_SAMPLE, 8'hFE, 3'd0, '0));
        stim_tbl.push_back(typed_row(KIND_TICK, 8'h55, 3'd1,
                           {NO_EVT, NO_EVT, NO_EVT, ev(2'd0, PRESS_LONG, 1'b1)}));
        stim_tbl.push_back(typed_row(KIND_SAMPLE, 8'hFF, 3'd0, '0));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'hF0));
        stim_tbl.push_back(typed_row(KIND_TICK, 8'hFF, 3'd4,
                           {ev(2'd3, PRESS_LONG, 1'b1), ev(2'd2, PRESS_LONG, 1'b0),
                            ev(2'd1, PRESS_LONG, 1'b0), ev(2'd0, PRESS_LONG, 1'b0)}));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'hFF));
        stim_tbl.push_back(cfg_row(REG_MASK_0, 16'h00));
        stim_tbl.push_back(cfg_row(REG_MASK_1, 16'hFF));
        stim_tbl.push_back(cfg_row(REG_MASK_2, 16'h81));
        stim_tbl.push_back(cfg_row(REG_MASK_3, 16'h3C));
        stim_tbl.push_back(cfg_row(REG_LONG_TICKS, 16'd2));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'h00));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'h7E));
        stim_tbl.push_back(item_row(KIND_TICK, 8'h00));
        stim_tbl.push_back(item_row(KIND_TICK, 8'hFF));
        stim_tbl.push_back(item_row(KIND_TICK, 8'h0F));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'hFF));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'h00));
        stim_tbl.push_back(item_row(KIND_TICK, 8'hF0));
        // lower the threshold under a held count: release and long press in one item
        stim_tbl.push_back(cfg_row(REG_LONG_TICKS, 16'd0));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'hFE));
        stim_tbl.push_back(item_row(KIND_SAMPLE, 8'hFF));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_tbl[k]) begin
            if (stim_tbl[k].op == ROW_CFG) begin
                wait_idle();
                apb_write(stim_tbl[k].cfg_reg, stim_tbl[k].cfg_value);
            end else begin
                send_item(stim_tbl[k].kind, stim_tbl[k].sample_byte, stim_tbl[k].typed,
                          stim_tbl[k].n_typed, stim_tbl[k].evts);
            end
        end
        wait_idle();

        last_byte = 8'hFF;
        for (p = 0; p < RAND_PHASES; p++) begin
            tx_idle = (p % 4 == 0) || (p % 4 == 2);
            rx_idle = (p % 4 == 0) || (p % 4 == 3);
            for (b = 0; b < NBTN; b++) begin
                case ($urandom_range(0, 3))
                    0: mask = 8'h00;
                    1: mask = 8'hFF;
                    2: mask = 8'h01 << b;
                    default: mask = 8'($urandom);
                endcase
                if (p == 3)
                    mask = 8'hFF;
                apb_write(bcls_reg_t'(b), {8'h00, mask});
            end
            case (p)
                0: lpt = 16'd0;
                1: lpt = 16'hFFFF;
                2: lpt = LPT_RESET;
                default: lpt = LPT_W'($urandom_range(1, 12));
            endcase
            apb_write(REG_LONG_TICKS, lpt);
            if (p == 3)
                rx_hold_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < 4) begin
                    kind = KIND_TICK;
                    sample_byte = 8'($urandom);
                end else begin
                    kind = KIND_SAMPLE;
                    case ($urandom_range(0, 9))
                        0, 1: sample_byte = 8'($urandom);
                        2: sample_byte = last_byte ^ (8'h01 << $urandom_range(0, 7))
                                                   ^ (8'h01 << $urandom_range(0, 7));
                        default: sample_byte = last_byte ^ (8'h01 << $urandom_range(0, 7));
                    endcase
                    last_byte = sample_byte;
                end
                send_item(kind, sample_byte, 1'b0, 3'd0, '0);
            end
            wait_idle();
        end

        if (err_count == 0 && press_events_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
